@@ src/swmv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmv_pkg - shared constants for the sliding window mean / variance block
// Field widths, register map and fixed-point scaling used by the top-level block.
// ----------------------------------------------------------------------------
package swmv_pkg;

    localparam int SCORE_W     = 32;  // signed Q16.16 score and mean
    localparam int LEN_W       = 5;   // window_length register field
    localparam int COUNT_W     = 5;   // entry_count result field
    localparam int SPREAD_W    = 47;  // variance result field
    localparam int FRAC_W      = 16;  // fraction bits dropped from the squares
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_PAD_W   = OUT_TDATA_W - COUNT_W - SCORE_W - SPREAD_W;
    localparam int CFG_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [SPREAD_W-1:0] SPREAD_MAX     = '1;
    localparam logic [LEN_W-1:0]    DEFAULT_LENGTH = 5'd10;

    // register index taken from paddr[2]
    localparam logic REG_WINDOW_LENGTH = 1'b0;

endpackage

`default_nettype wire

@@ src/swmv_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmv_div - iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module swmv_div #(
    parameter int DW = 53,
    parameter int CW = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [CW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quotient
);

    localparam int SCW = $clog2(DW + 1);

    logic           r_busy;
    logic           r_done;
    logic [SCW-1:0] r_step;
    logic [CW-1:0]  r_rem;
    logic [CW-1:0]  r_div;
    logic [DW-1:0]  r_quo;

    logic [CW:0] w_rem_sh;
    logic        w_ge;
    logic [CW:0] w_rem_nx;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[DW-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_div});
        w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= SCW'(DW);
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem  <= w_rem_nx[CW-1:0];
                r_quo  <= {r_quo[DW-2:0], w_ge};
                r_step <= r_step - SCW'(1);
                if (r_step == SCW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ src/sliding_window_mean_variance.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_mean_variance - windowed mean and population variance
// Keeps the most recent window_length scores and reports count, mean, variance.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one signed Q16.16 score per item. Each item is pushed into
//   the window and yields one m_axis item: entry count, mean (truncated toward
//   zero) and population variance (Q16.16 units, saturated at 2^47-1).
//   APB register 0 (byte address 0) is window_length; writing it empties the
//   window. Write it only while the block is idle.
// Processing:
//   Each item is worked through before the next can be accepted: two read
//   passes over the score memory (sum, then squared deviations) and two runs
//   of the shared one-bit-per-cycle divider (mean, then variance).
//   s_axis_tready is high only while no item is in work and no window_length
//   write is in its access cycle.
// Reset and stalls:
//   Reset empties the window and loads window_length = 10. A finished result
//   waits in the output register; a new item is accepted meanwhile, and its
//   result is held back until the earlier one is taken.
// ----------------------------------------------------------------------------
module sliding_window_mean_variance #(
    parameter int MAX_WINDOW = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // score [31:0]
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [swmv_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // entry_count [4:0], mean [36:5], spread [83:37], zero [87:84]
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [swmv_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [swmv_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [swmv_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [swmv_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);
    import swmv_pkg::*;

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int IW = $clog2(MAX_WINDOW);
    localparam int SW = SCORE_W + CW;
    localparam int AW = 2 * SCORE_W + CW;
    localparam int DW = AW - FRAC_W;
    localparam int EW = CW + LEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIV_MEAN,
        S_SQ,
        S_DIV_VAR,
        S_DONE
    } t_state;

    t_state r_state;

    logic [LEN_W-1:0]          r_wl;
    logic [IW-1:0]             r_wr_slot;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_idx;
    logic                      r_rd_vld;
    logic                      r_v2;
    logic                      r_v3;
    logic signed [SCORE_W-1:0] r_rd_data;
    logic signed [SW-1:0]      r_sum;
    logic signed [SCORE_W-1:0] r_mean;
    logic [SCORE_W-1:0]        r_mag;
    logic [2*SCORE_W-1:0]      r_sq;
    logic [AW-1:0]             r_acc;
    logic [SPREAD_W-1:0]       r_spread;
    logic                      r_out_valid;
    logic [OUT_TDATA_W-1:0]    r_out_tdata;

    logic [SCORE_W-1:0] r_mem [MAX_WINDOW];

    logic [IW-1:0]       n_wr_slot;
    logic [CW-1:0]       n_count;
    logic [EW-1:0]       w_wl_ext;
    logic [CW-1:0]       w_len;
    logic                w_in_acc;
    logic                w_cfg_wr;
    logic                w_rd_en;
    logic                w_sum_done;
    logic                w_sq_done;
    logic                w_div_start;
    logic [SW-1:0]       w_sum_mag;
    logic [DW-1:0]       w_div_dividend;
    logic                w_div_done;
    logic [DW-1:0]       w_div_quo;
    logic [SCORE_W-1:0]  w_mean_q;
    logic signed [SCORE_W:0] w_dev_a;
    logic signed [SCORE_W:0] w_dev_b;
    logic [EW-1:0]       w_count_ext;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[2] == REG_WINDOW_LENGTH);
    assign prdata   = (paddr[2] == REG_WINDOW_LENGTH)
                      ? {{(APB_DATA_W-LEN_W){1'b0}}, r_wl} : '0;

    // hold off input while a register write empties the window
    assign s_axis_tready = (r_state == S_IDLE) && !w_cfg_wr;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // clamp the register to 1..MAX_WINDOW
    always_comb begin
        w_wl_ext = {{CW{1'b0}}, r_wl};
        if (r_wl == '0) begin
            w_len = CW'(1);
        end else if (w_wl_ext > EW'(MAX_WINDOW)) begin
            w_len = CW'(MAX_WINDOW);
        end else begin
            w_len = w_wl_ext[CW-1:0];
        end
    end

    // the slot never reaches len, so wrap on slot + 1 == len
    always_comb begin
        if ((CW+1)'(r_wr_slot) + (CW+1)'(1) == (CW+1)'(w_len)) begin
            n_wr_slot = '0;
        end else begin
            n_wr_slot = r_wr_slot + IW'(1);
        end
        n_count = (r_count < w_len) ? r_count + CW'(1) : r_count;
    end

    // held entries always sit in slots 0 .. count-1
    assign w_rd_en    = ((r_state == S_SUM) || (r_state == S_SQ)) && (r_idx < r_count);
    assign w_sum_done = (r_state == S_SUM) && (r_idx == r_count) && !r_rd_vld;
    assign w_sq_done  = (r_state == S_SQ) && (r_idx == r_count)
                        && !r_rd_vld && !r_v2 && !r_v3;
    assign w_div_start = w_sum_done || w_sq_done;

    assign w_sum_mag      = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign w_div_dividend = (r_state == S_SUM) ? DW'(w_sum_mag) : r_acc[AW-1:FRAC_W];

    assign w_mean_q = r_sum[SW-1] ? (SCORE_W'(0) - w_div_quo[SCORE_W-1:0])
                                  : w_div_quo[SCORE_W-1:0];

    assign w_dev_a = {r_rd_data[SCORE_W-1], r_rd_data} - {r_mean[SCORE_W-1], r_mean};
    assign w_dev_b = {r_mean[SCORE_W-1], r_mean} - {r_rd_data[SCORE_W-1], r_rd_data};

    assign w_count_ext = {{LEN_W{1'b0}}, r_count};

    swmv_div #(
        .DW (DW),
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // score memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mem[r_wr_slot] <= s_axis_tdata[SCORE_W-1:0];
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wl        <= DEFAULT_LENGTH;
            r_wr_slot   <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                r_wl      <= pwdata[LEN_W-1:0];
                r_wr_slot <= '0;
                r_count   <= '0;
            end

            r_rd_vld <= w_rd_en;
            r_v2     <= r_rd_vld && (r_state == S_SQ);
            r_v3     <= r_v2;
            if (w_rd_en) begin
                r_idx <= r_idx + CW'(1);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_wr_slot <= n_wr_slot;
                        r_count   <= n_count;
                        r_idx     <= '0;
                        r_sum     <= '0;
                        r_state   <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_rd_vld) begin
                        r_sum <= r_sum + {{CW{r_rd_data[SCORE_W-1]}}, r_rd_data};
                    end
                    if (w_sum_done) begin
                        r_state <= S_DIV_MEAN;
                    end
                end
                S_DIV_MEAN: begin
                    if (w_div_done) begin
                        r_mean  <= w_mean_q;
                        r_idx   <= '0;
                        r_acc   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    // deviation magnitude, square, accumulate
                    if (r_rd_vld) begin
                        r_mag <= w_dev_a[SCORE_W] ? w_dev_b[SCORE_W-1:0]
                                                  : w_dev_a[SCORE_W-1:0];
                    end
                    if (r_v2) begin
                        r_sq <= r_mag * r_mag;
                    end
                    if (r_v3) begin
                        r_acc <= r_acc + AW'(r_sq);
                    end
                    if (w_sq_done) begin
                        r_state <= S_DIV_VAR;
                    end
                end
                S_DIV_VAR: begin
                    if (w_div_done) begin
                        r_spread <= (w_div_quo > DW'(SPREAD_MAX))
                                    ? SPREAD_MAX : w_div_quo[SPREAD_W-1:0];
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_tdata <= {{OUT_PAD_W{1'b0}}, r_spread, r_mean,
                                        w_count_ext[COUNT_W-1:0]};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;

endmodule

`default_nettype wire
